/* hdl/capability_token_filter_macros.svh */
// assertion macros for the capability token filter
`ifndef CAPABILITY_TOKEN_FILTER_MACROS_SVH
`define CAPABILITY_TOKEN_FILTER_MACROS_SVH

`ifndef SYNTH
`define CTF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ctf assertion failed");
`define CTF_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("ctf forbidden condition");
`else
`define CTF_ASSERT(lbl, clk, rst, prop)
`define CTF_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* hdl/ctf_pkg.sv */
// types, constants and byte helpers for the capability token filter
`timescale 1ns / 1ps
`default_nettype none
package ctf_pkg;

  localparam int PREFIX_DEPTH = 13;
  localparam int PRE_CW       = 4;
  localparam int AUTH_LEN     = 5;
  localparam int LD_LEN       = 13;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LL = 8'h6C;

  typedef enum logic [1:0] {
    PH_GAP,
    PH_PREFIX,
    PH_PASS,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAP,
    S_PRE,
    S_BYTE,
    S_CR,
    S_LF
  } ctf_state_t;

  typedef struct packed {
    logic in_valid;
    logic space;
    logic dec_gap;
    logic dec_pre;
    logic dec_byte;
    logic dec_end;
    logic has_pre;
    logic has_byte;
    logic has_end;
    logic gap_last;
    logic pre_last;
  } ctf_status_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic gap_load;
    logic pre_load;
    logic byte_load;
    logic cr_load;
    logic lf_load;
    logic gap_fix;
  } ctf_cmd_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    logic r;
    r = (b == CH_SP) || (b >= 8'h09 && b <= 8'h0D);
    return r;
  endfunction

  function automatic logic [7:0] kw_auth(input logic [PRE_CW-1:0] idx);
    logic [7:0] r;
    case (idx)
      4'd1: r = 8'h75;
      4'd2: r = 8'h74;
      4'd3: r = 8'h68;
      4'd4: r = 8'h3D;
      default: r = 8'h61;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_ld(input logic [PRE_CW-1:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0: r = 8'h6C;
      4'd1: r = 8'h6F;
      4'd2: r = 8'h67;
      4'd3: r = 8'h69;
      4'd4: r = 8'h6E;
      4'd5: r = 8'h64;
      4'd6: r = 8'h69;
      4'd7: r = 8'h73;
      4'd8: r = 8'h61;
      4'd9: r = 8'h62;
      4'd10: r = 8'h6C;
      4'd11: r = 8'h65;
      4'd12: r = 8'h64;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/ctf_if.sv */
// valid/ready byte channels for the capability token filter
`timescale 1ns / 1ps
`default_nettype none
interface ctf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface ctf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface
`default_nettype wire

/* hdl/ctf_datapath.sv */
// token filter datapath: token state, gap and prefix stores, output register
`timescale 1ns / 1ps
`default_nettype none
`include "capability_token_filter_macros.svh"
module ctf_datapath
  import ctf_pkg::*;
#(
  parameter int GAP_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  ctf_in_if.sink           raw,
  ctf_out_if.source        filtered,
  input  wire ctf_cmd_t    cmd,
  output ctf_status_t      st
);

  localparam int GCW = $clog2(GAP_DEPTH + 1);
  localparam int GAW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;

  phase_t             phase;
  logic [GCW-1:0]     gap_count;
  logic [PRE_CW-1:0]  prefix_count;
  logic               is_auth;
  logic [7:0]         cur_byte;
  logic [GCW-1:0]     n_gap;
  logic [PRE_CW-1:0]  n_pre;
  logic               has_byte;
  logic               has_end;
  logic               late;
  logic [GCW-1:0]     gidx;
  logic [PRE_CW-1:0]  pidx;
  logic [7:0]         gap_rdata;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;

  logic [7:0]         gap_mem [GAP_DEPTH];
  logic [7:0]         prefix_store [PREFIX_DEPTH];

  phase_t             phase_next;
  logic [GCW-1:0]     gap_count_next;
  logic [PRE_CW-1:0]  prefix_count_next;
  logic [PRE_CW-1:0]  pc_step;
  logic               is_auth_next;
  logic               fg;
  logic               fp_main;
  logic               fp_last;
  logic               eb;
  logic               gwe;
  logic [GAW-1:0]     gwa;
  logic               pwe;
  logic [PRE_CW-1:0]  pwa;
  logic               late_next;
  logic [GCW-1:0]     n_gap_next;
  logic [PRE_CW-1:0]  n_pre_next;
  logic [7:0]         lb;
  logic               ws;
  logic               delim;
  logic [7:0]         want;

  logic [GCW-1:0]     gidx_inc;
  logic [PRE_CW-1:0]  pidx_inc;
  logic               rd_en;
  logic [GAW-1:0]     rd_addr;
  logic               wr_en;
  logic [GAW-1:0]     wr_addr;
  logic [7:0]         wr_data;
  logic               load;
  logic [7:0]         load_byte;
  logic               load_last;

  // per-item decision
  always_comb begin
    lb                = to_lower(raw.in_byte);
    ws                = is_ws(raw.in_byte);
    delim             = (raw.in_byte == CH_SP) || (raw.in_byte == CH_CR) ||
                        (raw.in_byte == CH_LF);
    want              = is_auth ? kw_auth(prefix_count) : kw_ld(prefix_count);
    phase_next        = phase;
    gap_count_next    = gap_count;
    prefix_count_next = prefix_count;
    is_auth_next      = is_auth;
    fg                = 1'b0;
    fp_main           = 1'b0;
    fp_last           = 1'b0;
    eb                = 1'b0;
    gwe               = 1'b0;
    gwa               = '0;
    pwe               = 1'b0;
    pwa               = prefix_count;
    late_next         = 1'b0;
    case (phase)
      PH_GAP: begin
        if (ws) begin
          if (gap_count < GCW'(GAP_DEPTH)) begin
            gwe            = 1'b1;
            gwa            = gap_count[GAW-1:0];
            gap_count_next = gap_count + 1'b1;
          end
        end else if (lb == CH_LA || lb == CH_LL) begin
          pwe               = 1'b1;
          pwa               = '0;
          prefix_count_next = PRE_CW'(1);
          phase_next        = PH_PREFIX;
          is_auth_next      = (lb == CH_LA);
        end else begin
          fg             = 1'b1;
          eb             = 1'b1;
          gap_count_next = '0;
          phase_next     = PH_PASS;
        end
      end
      PH_PREFIX: begin
        if (prefix_count >= PRE_CW'(LD_LEN)) begin
          if (ws) begin
            gap_count_next    = '0;
            prefix_count_next = '0;
            phase_next        = PH_SKIP;
            if (delim) begin
              phase_next     = PH_GAP;
              gap_count_next = GCW'(1);
              gwe            = 1'b1;
            end
          end else begin
            fg                = 1'b1;
            fp_main           = 1'b1;
            eb                = 1'b1;
            gap_count_next    = '0;
            prefix_count_next = '0;
            phase_next        = PH_PASS;
          end
        end else if (ws) begin
          // gap entry zero is rewritten once the old gap has gone out
          fg                = 1'b1;
          fp_main           = 1'b1;
          prefix_count_next = '0;
          gap_count_next    = GCW'(1);
          phase_next        = PH_GAP;
          late_next         = 1'b1;
        end else if (lb == want) begin
          pwe               = 1'b1;
          prefix_count_next = prefix_count + 1'b1;
          if (is_auth && prefix_count_next >= PRE_CW'(AUTH_LEN)) begin
            gap_count_next    = '0;
            prefix_count_next = '0;
            phase_next        = PH_SKIP;
          end
        end else begin
          fg                = 1'b1;
          fp_main           = 1'b1;
          eb                = 1'b1;
          gap_count_next    = '0;
          prefix_count_next = '0;
          phase_next        = PH_PASS;
        end
      end
      PH_PASS: begin
        if (ws) begin
          phase_next     = PH_GAP;
          gap_count_next = GCW'(1);
          gwe            = 1'b1;
        end else begin
          eb = 1'b1;
        end
      end
      default: begin
        if (delim) begin
          phase_next     = PH_GAP;
          gap_count_next = GCW'(1);
          gwe            = 1'b1;
        end
      end
    endcase
    pc_step = prefix_count_next;
    if (raw.in_last) begin
      if (phase_next == PH_PREFIX && prefix_count_next < PRE_CW'(LD_LEN)) begin
        fg      = 1'b1;
        fp_last = 1'b1;
      end
      gap_count_next    = '0;
      prefix_count_next = '0;
      phase_next        = PH_GAP;
    end
    n_gap_next = fg ? gap_count : '0;
    n_pre_next = fp_main ? prefix_count : (fp_last ? pc_step : '0);
  end

  assign gidx_inc = gidx + 1'b1;
  assign pidx_inc = pidx + 1'b1;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (cmd.accept && n_gap_next != '0) begin
      rd_en = 1'b1;
    end else if (cmd.gap_load && gidx_inc < n_gap) begin
      rd_en   = 1'b1;
      rd_addr = gidx_inc[GAW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = gwa;
    wr_data = raw.in_byte;
    if (cmd.accept && gwe) begin
      wr_en = 1'b1;
    end else if (cmd.gap_fix && late) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      gap_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      gap_rdata <= gap_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && pwe) begin
      prefix_store[pwa] <= raw.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_GAP;
      gap_count    <= '0;
      prefix_count <= '0;
      is_auth      <= 1'b0;
      n_gap        <= '0;
      n_pre        <= '0;
      has_byte     <= 1'b0;
      has_end      <= 1'b0;
      late         <= 1'b0;
    end else if (cmd.accept) begin
      phase        <= phase_next;
      gap_count    <= gap_count_next;
      prefix_count <= prefix_count_next;
      is_auth      <= is_auth_next;
      n_gap        <= n_gap_next;
      n_pre        <= n_pre_next;
      has_byte     <= eb;
      has_end      <= raw.in_last;
      late         <= late_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_byte <= raw.in_byte;
      gidx     <= '0;
      pidx     <= '0;
    end else begin
      if (cmd.gap_load) begin
        gidx <= gidx_inc;
      end
      if (cmd.pre_load) begin
        pidx <= pidx_inc;
      end
    end
  end

  // output register
  always_comb begin
    load      = cmd.gap_load | cmd.pre_load | cmd.byte_load | cmd.cr_load | cmd.lf_load;
    load_last = cmd.lf_load;
    load_byte = CH_LF;
    if (cmd.gap_load) begin
      load_byte = gap_rdata;
    end else if (cmd.pre_load) begin
      load_byte = prefix_store[pidx];
    end else if (cmd.byte_load) begin
      load_byte = cur_byte;
    end else if (cmd.cr_load) begin
      load_byte = CH_CR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

  assign filtered.valid    = out_valid;
  assign filtered.out_byte = out_byte;
  assign filtered.out_last = out_last;
  assign raw.ready         = cmd.ready;

  always_comb begin
    st.in_valid = raw.valid;
    st.space    = !out_valid || filtered.ready;
    st.dec_gap  = n_gap_next != '0;
    st.dec_pre  = n_pre_next != '0;
    st.dec_byte = eb;
    st.dec_end  = raw.in_last;
    st.has_pre  = n_pre != '0;
    st.has_byte = has_byte;
    st.has_end  = has_end;
    st.gap_last = gidx_inc == n_gap;
    st.pre_last = pidx_inc == n_pre;
  end

  `CTF_ASSERT(a_last_is_lf, clk, rst, (out_valid && out_last) |-> (out_byte == CH_LF))
  `CTF_NEVER(a_gap_bound, clk, rst, gap_count > GCW'(GAP_DEPTH))
  `CTF_NEVER(a_prefix_bound, clk, rst, prefix_count > PRE_CW'(LD_LEN))
  `CTF_ASSERT(a_prefix_held, clk, rst, (phase == PH_PREFIX) |-> (prefix_count != '0))
  `CTF_ASSERT(a_gap_flush_in_range, clk, rst, cmd.gap_load |-> (gidx < n_gap))

endmodule
`default_nettype wire

/* hdl/ctf_ctrl.sv */
// token filter controller: sequences the bytes that one transfer releases
`timescale 1ns / 1ps
`default_nettype none
module ctf_ctrl
  import ctf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctf_status_t st,
  output ctf_cmd_t         cmd
);

  ctf_state_t state;
  ctf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (st.in_valid) begin
          if (st.dec_gap) begin
            state_next = S_GAP;
          end else if (st.dec_pre) begin
            state_next = S_PRE;
          end else if (st.dec_byte) begin
            state_next = S_BYTE;
          end else if (st.dec_end) begin
            state_next = S_CR;
          end
        end
      end
      S_GAP: begin
        if (st.space && st.gap_last) begin
          if (st.has_pre) begin
            state_next = S_PRE;
          end else if (st.has_byte) begin
            state_next = S_BYTE;
          end else if (st.has_end) begin
            state_next = S_CR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PRE: begin
        if (st.space && st.pre_last) begin
          if (st.has_byte) begin
            state_next = S_BYTE;
          end else if (st.has_end) begin
            state_next = S_CR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_BYTE: begin
        if (st.space) begin
          state_next = st.has_end ? S_CR : S_IDLE;
        end
      end
      S_CR: begin
        if (st.space) begin
          state_next = S_LF;
        end
      end
      S_LF: begin
        if (st.space) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.ready     = state == S_IDLE;
    cmd.accept    = (state == S_IDLE) && st.in_valid;
    cmd.gap_load  = (state == S_GAP) && st.space;
    cmd.pre_load  = (state == S_PRE) && st.space;
    cmd.byte_load = (state == S_BYTE) && st.space;
    cmd.cr_load   = (state == S_CR) && st.space;
    cmd.lf_load   = (state == S_LF) && st.space;
    cmd.gap_fix   = state == S_PRE;
  end

endmodule
`default_nettype wire

/* hdl/capability_token_filter.sv */
// Capability token filter, top level. Bytes of a capability list enter on raw,
// one per transfer, with in_last on the final byte; the filtered list leaves on
// filtered, closed by CR LF with out_last on the LF. AUTH= tokens and a
// LOGINDISABLED token followed by whitespace or the end of the list are removed
// with their leading whitespace; up to GAP_DEPTH leading whitespace bytes are
// kept per gap. For a byte that releases output, the controller loads each
// released byte in turn (held gap, held prefix of up to 13 bytes, the byte
// itself, CR and LF) into the single output register, one byte per cycle
// while that register has space; stalls on filtered hold it back. The gap
// store has one read port. The output register lets the next byte be taken
// while the last result waits.
`timescale 1ns / 1ps
`default_nettype none
module capability_token_filter
  import ctf_pkg::*;
#(
  parameter int GAP_DEPTH = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ctf_in_if.sink      raw,
  ctf_out_if.source   filtered
);

  ctf_status_t st;
  ctf_cmd_t    cmd;

  ctf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  ctf_datapath #(
    .GAP_DEPTH (GAP_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw),
    .filtered (filtered),
    .cmd      (cmd),
    .st       (st)
  );

endmodule
`default_nettype wire
